// ===== rtl/pll_pkg.sv =====
`default_nettype none

package pll_pkg;

   localparam int RAW_W   = 17;   // difference of two Q8.8 coordinates
   localparam int MAG_W   = 16;   // magnitude of a raw component
   localparam int SQ_W    = 34;   // sum of three squared magnitudes
   localparam int LEN_W   = 17;   // integer square root of SQ_W bits
   localparam int COORD_W = 16;
   localparam int COLOR_W = 8;
   localparam int OUT_W   = 16;
   localparam int SHIN_W  = 8;
   localparam int LT_W    = 24;   // color * intensity in Q8.8
   localparam int TK_W    = 32;   // light strength times material factor
   localparam int TERM_W  = 33;
   localparam int ACC_W   = 35;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [2:0] {
      REG_LIGHT_POS     = 3'd0,
      REG_CAMERA_POS    = 3'd1,
      REG_LIGHT_COLOR   = 3'd2,
      REG_LIGHT_INT     = 3'd3,
      REG_AMBIENT_COLOR = 3'd4,
      REG_AMBIENT_INT   = 3'd5,
      REG_MATERIAL      = 3'd6,
      REG_SHININESS     = 3'd7
   } csr_index_type;

   typedef logic [RAW_W-1:0] raw_type;

   typedef struct packed {
      raw_type [2:0]              nr;
      raw_type [2:0]              lr;
      raw_type [2:0]              vr;
      logic [2:0][COLOR_W-1:0]    rgb;
   } frag_type;

   typedef struct packed {
      logic [47:0]       light_position;
      logic [47:0]       camera_position;
      logic [47:0]       light_color;
      logic [15:0]       light_intensity;
      logic [47:0]       ambient_color;
      logic [15:0]       ambient_intensity;
      logic [31:0]       material_factors;
      logic [SHIN_W-1:0] shininess;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      light_position:    48'd0,
      camera_position:   48'd0,
      light_color:       48'd0,
      light_intensity:   16'd256,
      ambient_color:     48'd0,
      ambient_intensity: 16'd0,
      material_factors:  32'h0100_0100,
      shininess:         8'd32
   };

   // channel 0 is x or r in the top bits
   function automatic logic [15:0] chan16(input logic [47:0] v, input int c);
      logic [15:0] res;
      case (c)
         0:       res = v[47:32];
         1:       res = v[31:16];
         default: res = v[15:0];
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/pll_ifs.sv =====
`default_nettype none

interface pll_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] pos_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic [7:0]         base_r;
   logic [7:0]         base_g;
   logic [7:0]         base_b;

   modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   base_r, base_g, base_b, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 base_r, base_g, base_b, output ready);
endinterface

interface pll_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_r;
   logic [15:0] out_g;
   logic [15:0] out_b;

   modport source (output valid, out_r, out_g, out_b, input ready);
   modport sink (input valid, out_r, out_g, out_b, output ready);
endinterface

interface pll_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pll_front.sv =====
`default_nettype none

module pll_front (
   input  logic              clock,
   input  logic              reset,
   pll_req_if.sink           req,
   input  pll_pkg::cfg_type  cfg,
   output pll_pkg::frag_type frag_o,
   output logic              frag_vld_o,
   input  logic              frag_rdy_i
);
   import pll_pkg::*;

   logic     vld_ff, vld_in;
   frag_type frag_ff, frag_in;
   logic     accept;

   logic signed [COORD_W-1:0] pos [3];
   logic signed [COORD_W-1:0] nrm [3];

   assign pos[0] = req.pos_x;
   assign pos[1] = req.pos_y;
   assign pos[2] = req.pos_z;
   assign nrm[0] = req.norm_x;
   assign nrm[1] = req.norm_y;
   assign nrm[2] = req.norm_z;

   assign req.ready = !vld_ff || frag_rdy_i;
   assign accept    = req.valid && req.ready;

   // rays from the fragment toward light and camera, one bit wider
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         frag_in.nr[i] = RAW_W'(nrm[i]);
         frag_in.lr[i] = RAW_W'($signed(chan16(cfg.light_position, i))) - RAW_W'(pos[i]);
         frag_in.vr[i] = RAW_W'($signed(chan16(cfg.camera_position, i))) - RAW_W'(pos[i]);
      end
      frag_in.rgb[0] = req.base_r;
      frag_in.rgb[1] = req.base_g;
      frag_in.rgb[2] = req.base_b;
   end

   always_comb begin
      if (accept) begin
         vld_in = 1'b1;
      end else if (frag_rdy_i) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frag_ff <= frag_in;
      end
   end

   assign frag_o     = frag_ff;
   assign frag_vld_o = vld_ff;

endmodule

`default_nettype wire

// ===== rtl/pll_queue.sv =====
`default_nettype none

module pll_queue (
   input  logic              clock,
   input  logic              reset,
   input  pll_pkg::frag_type push_data,
   input  logic              push_vld,
   output logic              push_rdy,
   output pll_pkg::frag_type pop_data,
   output logic              pop_vld,
   input  logic              pop_rdy
);
   import pll_pkg::*;

   frag_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                push, pop;

   assign push_rdy = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_vld  = cnt_ff != '0;
   assign pop_data = q_ff[rd_ptr_ff];
   assign push     = push_vld && push_rdy;
   assign pop      = pop_vld && pop_rdy;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pll_unit3.sv =====
`default_nettype none

// normalizes one vector: squares, one root bit per stage, one quotient bit per stage
module pll_unit3 #(
   parameter int FRAC_BITS = 14
) (
   input  logic                         clock,
   input  logic                         ce,
   input  pll_pkg::raw_type [2:0]       vec_i,
   output logic [2:0][FRAC_BITS+1:0]    unit_o
);
   import pll_pkg::*;

   localparam int NSQ = LEN_W;
   localparam int QW  = FRAC_BITS + 1;
   localparam int NW  = FRAC_BITS + 2;
   localparam int DW  = MAG_W + FRAC_BITS + 1;

   logic [2:0][MAG_W-1:0] mag_ff  [0:NSQ];
   logic [2:0]            neg_ff  [0:NSQ];
   logic [SQ_W-1:0]       rem_ff  [0:NSQ];
   logic [LEN_W-1:0]      root_ff [0:NSQ];

   logic [2:0][DW-1:0]    dr_ff [0:QW];
   logic [2:0][QW-1:0]    dq_ff [0:QW];
   logic [LEN_W-1:0]      dl_ff [0:QW];
   logic [2:0]            dn_ff [0:QW];

   logic [2:0][NW-1:0]    unit_ff;

   logic [RAW_W-1:0]      absv [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         absv[i] = vec_i[i][RAW_W-1] ? (~vec_i[i] + RAW_W'(1)) : vec_i[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[0][i] <= absv[i][MAG_W-1:0];
            neg_ff[0][i] <= vec_i[i][RAW_W-1];
         end
         rem_ff[0]  <= SQ_W'(absv[0][MAG_W-1:0]) * SQ_W'(absv[0][MAG_W-1:0])
                     + SQ_W'(absv[1][MAG_W-1:0]) * SQ_W'(absv[1][MAG_W-1:0])
                     + SQ_W'(absv[2][MAG_W-1:0]) * SQ_W'(absv[2][MAG_W-1:0]);
         root_ff[0] <= '0;
      end
   end

   // rem holds sq - root^2; trial is the growth of root^2 when bit K is set
   for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
      localparam int K = NSQ - 1 - j;
      logic [SQ_W:0] trial;

      assign trial = ((SQ_W+1)'(root_ff[j]) << (K + 1)) | ((SQ_W+1)'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (ce) begin
            if ({1'b0, rem_ff[j]} >= trial) begin
               rem_ff[j+1]  <= rem_ff[j] - trial[SQ_W-1:0];
               root_ff[j+1] <= root_ff[j] | (LEN_W'(1) << K);
            end else begin
               rem_ff[j+1]  <= rem_ff[j];
               root_ff[j+1] <= root_ff[j];
            end
            mag_ff[j+1] <= mag_ff[j];
            neg_ff[j+1] <= neg_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            dr_ff[0][i] <= DW'(mag_ff[NSQ][i]) << FRAC_BITS;
         end
         dq_ff[0] <= '0;
         dl_ff[0] <= root_ff[NSQ];
         dn_ff[0] <= neg_ff[NSQ];
      end
   end

   // quotient never reaches 2^(FRAC_BITS+1) since the length covers each component
   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int K = FRAC_BITS - j;
      logic [DW-1:0] dsub;

      assign dsub = DW'(dl_ff[j]) << K;

      always_ff @(posedge clock) begin
         if (ce) begin
            for (int i = 0; i < 3; i++) begin
               if (dl_ff[j] != '0 && dr_ff[j][i] >= dsub) begin
                  dr_ff[j+1][i] <= dr_ff[j][i] - dsub;
                  dq_ff[j+1][i] <= dq_ff[j][i] | (QW'(1) << K);
               end else begin
                  dr_ff[j+1][i] <= dr_ff[j][i];
                  dq_ff[j+1][i] <= dq_ff[j][i];
               end
            end
            dl_ff[j+1] <= dl_ff[j];
            dn_ff[j+1] <= dn_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            unit_ff[i] <= dn_ff[QW][i] ? (~NW'(dq_ff[QW][i]) + NW'(1)) : NW'(dq_ff[QW][i]);
         end
      end
   end

   assign unit_o = unit_ff;

endmodule

`default_nettype wire

// ===== rtl/pll_back.sv =====
`default_nettype none

module pll_back #(
   parameter int FRAC_BITS = 14
) (
   input  logic              clock,
   input  logic              reset,
   input  pll_pkg::frag_type frag_i,
   input  logic              frag_vld_i,
   output logic              frag_rdy_o,
   input  pll_pkg::cfg_type  cfg,
   pll_rsp_if.source         rsp
);
   import pll_pkg::*;

   localparam int UNIT_LAT = LEN_W + FRAC_BITS + 4;
   localparam int VL       = UNIT_LAT + 16;
   localparam int QW       = FRAC_BITS + 1;
   localparam int NW       = FRAC_BITS + 2;
   localparam int PW       = 2 * NW;
   localparam int DOTW     = PW + 2;
   localparam int NLW      = DOTW - FRAC_BITS;
   localparam int PRW      = NLW + NW + 1;
   localparam int RW       = FRAC_BITS + 5;
   localparam int VPW      = NW + RW;
   localparam int DVW      = VPW + 2;
   localparam int PQW      = 2 * QW;
   localparam int PTW      = TK_W + QW;
   localparam int OPW      = ACC_W + COLOR_W;
   localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

   logic ce;
   logic [VL-1:0] vld_ff;
   logic          out_vld_ff;
   logic [OUT_W-1:0] out_ff [3];

   assign ce         = !out_vld_ff || rsp.ready;
   assign frag_rdy_o = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (ce) begin
         vld_ff     <= {vld_ff[VL-2:0], frag_vld_i};
         out_vld_ff <= vld_ff[VL-1];
      end
   end

   // per-channel light terms depend on configuration only
   logic [LT_W-1:0] t_ff [3];
   logic [LT_W-1:0] a_ff [3];
   logic [TK_W-1:0] td_ff [3];
   logic [TK_W-1:0] ts_ff [3];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         t_ff[i]  <= LT_W'((32'(chan16(cfg.light_color, i)) * 32'(cfg.light_intensity)) >> 8);
         a_ff[i]  <= LT_W'((32'(chan16(cfg.ambient_color, i))
                            * 32'(cfg.ambient_intensity)) >> 8);
         td_ff[i] <= TK_W'((40'(t_ff[i]) * 40'(cfg.material_factors[31:16])) >> 8);
         ts_ff[i] <= TK_W'((40'(t_ff[i]) * 40'(cfg.material_factors[15:0])) >> 8);
      end
   end

   // normalize N, L and V
   logic [2:0][NW-1:0] un, ul, uv;

   pll_unit3 #(.FRAC_BITS(FRAC_BITS)) u_norm_n (
      .clock(clock), .ce(ce), .vec_i(frag_i.nr), .unit_o(un));
   pll_unit3 #(.FRAC_BITS(FRAC_BITS)) u_norm_l (
      .clock(clock), .ce(ce), .vec_i(frag_i.lr), .unit_o(ul));
   pll_unit3 #(.FRAC_BITS(FRAC_BITS)) u_norm_v (
      .clock(clock), .ce(ce), .vec_i(frag_i.vr), .unit_o(uv));

   logic [2:0][COLOR_W-1:0] rgb_dl_ff [UNIT_LAT];

   always_ff @(posedge clock) begin
      if (ce) begin
         rgb_dl_ff[0] <= frag_i.rgb;
         for (int s = 1; s < UNIT_LAT; s++) begin
            rgb_dl_ff[s] <= rgb_dl_ff[s-1];
         end
      end
   end

   // N.L products
   logic signed [PW-1:0] pnl_ff [3];
   logic signed [NW-1:0] n1_ff [3], l1_ff [3], v1_ff [3];
   logic [2:0][COLOR_W-1:0] rgb1_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            pnl_ff[i] <= PW'($signed(un[i])) * PW'($signed(ul[i]));
            n1_ff[i]  <= $signed(un[i]);
            l1_ff[i]  <= $signed(ul[i]);
            v1_ff[i]  <= $signed(uv[i]);
         end
         rgb1_ff <= rgb_dl_ff[UNIT_LAT-1];
      end
   end

   // N.L sum, diffuse clamp, N.L back to QF toward zero
   logic signed [DOTW-1:0] dnl;
   logic [DOTW-1:0]        dnl_mag;
   logic signed [NLW-1:0]  nl_in, nl_ff;
   logic [QW-1:0]          diff_in, diff2_ff;
   logic signed [NW-1:0]   n2_ff [3], l2_ff [3], v2_ff [3];
   logic [2:0][COLOR_W-1:0] rgb2_ff;

   always_comb begin
      dnl     = DOTW'(pnl_ff[0]) + DOTW'(pnl_ff[1]) + DOTW'(pnl_ff[2]);
      dnl_mag = $unsigned(dnl[DOTW-1] ? -dnl : dnl) >> FRAC_BITS;
      nl_in   = dnl[DOTW-1] ? -$signed(NLW'(dnl_mag)) : $signed(NLW'(dnl_mag));
      if (dnl[DOTW-1] || dnl == '0) begin
         diff_in = '0;
      end else if (dnl_mag > DOTW'(ONE_Q)) begin
         diff_in = ONE_Q;
      end else begin
         diff_in = dnl_mag[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         nl_ff    <= nl_in;
         diff2_ff <= diff_in;
         n2_ff    <= n1_ff;
         l2_ff    <= l1_ff;
         v2_ff    <= v1_ff;
         rgb2_ff  <= rgb1_ff;
      end
   end

   // 2(N.L)N
   logic signed [PRW-1:0]  pr_ff [3];
   logic signed [NW-1:0]   l3_ff [3], v3_ff [3];
   logic [QW-1:0]          diff3_ff;
   logic [2:0][COLOR_W-1:0] rgb3_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            pr_ff[i] <= (PRW'(nl_ff) * PRW'(n2_ff[i])) <<< 1;
         end
         l3_ff    <= l2_ff;
         v3_ff    <= v2_ff;
         diff3_ff <= diff2_ff;
         rgb3_ff  <= rgb2_ff;
      end
   end

   // R = -L + 2(N.L)N, the 2(N.L)N term truncated toward zero
   logic [PRW-1:0]         prm [3];
   logic signed [RW-1:0]   r_in [3], r_ff [3];
   logic signed [NW-1:0]   v4_ff [3];
   logic [QW-1:0]          diff4_ff;
   logic [2:0][COLOR_W-1:0] rgb4_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prm[i]  = $unsigned(pr_ff[i][PRW-1] ? -pr_ff[i] : pr_ff[i]) >> FRAC_BITS;
         r_in[i] = (pr_ff[i][PRW-1] ? -$signed(RW'(prm[i])) : $signed(RW'(prm[i])))
                   - RW'(l3_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         r_ff     <= r_in;
         v4_ff    <= v3_ff;
         diff4_ff <= diff3_ff;
         rgb4_ff  <= rgb3_ff;
      end
   end

   // V.R products
   logic signed [VPW-1:0]  pvr_ff [3];
   logic [QW-1:0]          diff5_ff;
   logic [2:0][COLOR_W-1:0] rgb5_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            pvr_ff[i] <= VPW'(v4_ff[i]) * VPW'(r_ff[i]);
         end
         diff5_ff <= diff4_ff;
         rgb5_ff  <= rgb4_ff;
      end
   end

   // V.R sum and clamp seed the power chain
   logic signed [DVW-1:0]  dvr;
   logic [DVW-1:0]         dvr_sh;
   logic [QW-1:0]          base_in;
   logic [QW-1:0]          sp_ff [0:8];
   logic [QW-1:0]          pb_ff [0:8];
   logic [QW-1:0]          pdiff_ff [0:8];
   logic [2:0][COLOR_W-1:0] prgb_ff [0:8];

   always_comb begin
      dvr    = DVW'(pvr_ff[0]) + DVW'(pvr_ff[1]) + DVW'(pvr_ff[2]);
      dvr_sh = $unsigned(dvr) >> FRAC_BITS;
      if (dvr[DVW-1] || dvr == '0) begin
         base_in = '0;
      end else if (dvr_sh > DVW'(ONE_Q)) begin
         base_in = ONE_Q;
      end else begin
         base_in = dvr_sh[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sp_ff[0]    <= ONE_Q;
         pb_ff[0]    <= base_in;
         pdiff_ff[0] <= diff5_ff;
         prgb_ff[0]  <= rgb5_ff;
      end
   end

   // square and multiply, one exponent bit per stage
   for (genvar e = 0; e < SHIN_W; e++) begin : g_pow
      logic [PQW-1:0] sp_prod, pb_prod;

      assign sp_prod = PQW'(sp_ff[e]) * PQW'(pb_ff[e]);
      assign pb_prod = PQW'(pb_ff[e]) * PQW'(pb_ff[e]);

      always_ff @(posedge clock) begin
         if (ce) begin
            sp_ff[e+1]    <= cfg.shininess[e] ? QW'(sp_prod >> FRAC_BITS) : sp_ff[e];
            pb_ff[e+1]    <= QW'(pb_prod >> FRAC_BITS);
            pdiff_ff[e+1] <= pdiff_ff[e];
            prgb_ff[e+1]  <= prgb_ff[e];
         end
      end
   end

   // diffuse and specular terms
   logic [TERM_W-1:0]       d_ff [3], s_ff [3];
   logic [2:0][COLOR_W-1:0] rgbf1_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= TERM_W'((PTW'(td_ff[i]) * PTW'(pdiff_ff[SHIN_W])) >> FRAC_BITS);
            s_ff[i] <= TERM_W'((PTW'(ts_ff[i]) * PTW'(sp_ff[SHIN_W])) >> FRAC_BITS);
         end
         rgbf1_ff <= prgb_ff[SHIN_W];
      end
   end

   logic [ACC_W-1:0]        acc_ff [3];
   logic [2:0][COLOR_W-1:0] rgbf2_ff;

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            acc_ff[i] <= ACC_W'(a_ff[i]) + ACC_W'(d_ff[i]) + ACC_W'(s_ff[i]);
         end
         rgbf2_ff <= rgbf1_ff;
      end
   end

   // base color scale and saturation into the output register
   logic [OPW-1:0] lit [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lit[i] = (OPW'(acc_ff[i]) * OPW'(rgbf2_ff[i])) >> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= (lit[i] > OPW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : lit[i][OUT_W-1:0];
         end
      end
   end

   assign rsp.valid = out_vld_ff;
   assign rsp.out_r = out_ff[0];
   assign rsp.out_g = out_ff[1];
   assign rsp.out_b = out_ff[2];

endmodule

`default_nettype wire

// ===== rtl/phong_fragment_lighting_top.sv =====
// Per-fragment Phong lighting.
// req_chan carries one fragment word (position, unnormalized normal, base
// color); rsp_chan returns one lit color word per fragment, in order.
// csr_chan writes the light, camera, color, material and shininess registers
// by index; it is always ready and should only be used while no fragment is
// in flight.
// Throughput: one fragment per cycle, sustained while rsp_chan.ready is high.
// Pipeline depth is set by the normalize units, which resolve one square
// root bit per stage (17 stages) and one quotient bit per stage
// (FRAC_BITS + 1 stages), followed by the dot products and the eight-stage
// square-and-multiply power chain.
// The front stage and a four-word queue decouple req_chan from the shading
// pipeline; while rsp_chan holds an untaken word the pipeline holds and the
// queue keeps taking fragments until it fills, then req_chan.ready drops.
// Reset (synchronous) empties the pipeline and queue and loads the register
// defaults: light intensity 1.0, both material factors 1.0, shininess 32.
`default_nettype none

module phong_fragment_lighting_top #(
   parameter int FRAC_BITS = 14
) (
   input  logic       clock,
   input  logic       reset,
   pll_req_if.sink    req_chan,
   pll_rsp_if.source  rsp_chan,
   pll_csr_if.sink    csr_chan
);
   import pll_pkg::*;

   cfg_type  cfg_ff;
   frag_type front_frag, q_frag;
   logic     front_vld, front_rdy;
   logic     q_vld, q_rdy;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            REG_LIGHT_POS:     cfg_ff.light_position    <= csr_chan.data;
            REG_CAMERA_POS:    cfg_ff.camera_position   <= csr_chan.data;
            REG_LIGHT_COLOR:   cfg_ff.light_color       <= csr_chan.data;
            REG_LIGHT_INT:     cfg_ff.light_intensity   <= csr_chan.data[15:0];
            REG_AMBIENT_COLOR: cfg_ff.ambient_color     <= csr_chan.data;
            REG_AMBIENT_INT:   cfg_ff.ambient_intensity <= csr_chan.data[15:0];
            REG_MATERIAL:      cfg_ff.material_factors  <= csr_chan.data[31:0];
            REG_SHININESS:     cfg_ff.shininess         <= csr_chan.data[SHIN_W-1:0];
            default: ;
         endcase
      end
   end

   pll_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg_ff),
      .frag_o     (front_frag),
      .frag_vld_o (front_vld),
      .frag_rdy_i (front_rdy)
   );

   pll_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_data (front_frag),
      .push_vld  (front_vld),
      .push_rdy  (front_rdy),
      .pop_data  (q_frag),
      .pop_vld   (q_vld),
      .pop_rdy   (q_rdy)
   );

   pll_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .frag_i     (q_frag),
      .frag_vld_i (q_vld),
      .frag_rdy_o (q_rdy),
      .cfg        (cfg_ff),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== rtl/pll_checker.sv =====
`default_nettype none

module pll_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] out_r,
   input logic [15:0] out_g,
   input logic [15:0] out_b
);

   logic [7:0] pend_ff;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (req_take && !rsp_take) begin
         pend_ff <= pend_ff + 8'd1;
      end else if (rsp_take && !req_take) begin
         pend_ff <= pend_ff - 8'd1;
      end
   end

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 8'd0)
      else $error("response word without an outstanding fragment");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({out_r, out_g, out_b}))
      else $error("response word changed while stalled");

endmodule

bind phong_fragment_lighting_top pll_checker u_pll_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_r     (rsp_chan.out_r),
   .out_g     (rsp_chan.out_g),
   .out_b     (rsp_chan.out_b)
);

`default_nettype wire

// ===== tb/phong_fragment_lighting_top_tb.sv =====
`default_nettype none

module phong_fragment_lighting_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pll_pkg::*;

   localparam int FB      = 14;
   localparam int LATENCY = FB + 39;

   typedef longint vec3_t[3];

   typedef struct {
      logic signed [15:0] px, py, pz;
      logic signed [15:0] nx, ny, nz;
      logic [7:0]         br, bg, bb;
   } frag_t;

   typedef struct {
      logic [15:0] r, g, b;
   } color_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pll_req_if req_if ();
   pll_rsp_if rsp_if ();
   pll_csr_if csr_if ();

   phong_fragment_lighting_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   cfg_type lighting;
   frag_t   frags_to_send[$];
   color_t  colors_due[$];
   frag_t   frag_on_bus;
   int      req_gap, rsp_gap;
   bit      allow_gaps;
   int      mismatches;

   // ---------------- predictor ----------------
   function automatic longint lane(logic [47:0] v, int i);
      return longint'($signed(v[47-16*i -: 16]));
   endfunction

   function automatic longint unsigned ulane(logic [47:0] v, int i);
      return longint'(v[47-16*i -: 16]);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic vec3_t unit_vec(vec3_t c);
      vec3_t u;
      longint unsigned sq, len, m, q;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         m = (c[i] < 0) ? -c[i] : c[i];
         sq += m * m;
      end
      len = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
         m = (c[i] < 0) ? -c[i] : c[i];
         q = (len == 0) ? 0 : (m << FB) / len;
         u[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
      return u;
   endfunction

   function automatic longint trunc_shift(longint v);
      return (v < 0) ? -((-v) >> FB) : (v >> FB);
   endfunction

   function automatic longint unsigned clamp_one(longint d);
      longint unsigned x;
      if (d <= 0) return 0;
      x = longint'(d) >> FB;
      return (x > (64'd1 << FB)) ? (64'd1 << FB) : x;
   endfunction

   function automatic color_t shade(frag_t f);
      vec3_t nr, lr, vr, n, l, v, refl;
      longint p[3];
      longint nl;
      longint unsigned diff, spb, spec, kd, ks, t, d, s, a, o;
      logic [7:0] base[3];
      logic [15:0] res[3];
      color_t c;
      p[0] = f.px; p[1] = f.py; p[2] = f.pz;
      nr[0] = f.nx; nr[1] = f.ny; nr[2] = f.nz;
      base[0] = f.br; base[1] = f.bg; base[2] = f.bb;
      for (int i = 0; i < 3; i++) begin
         lr[i] = lane(lighting.light_position, i) - p[i];
         vr[i] = lane(lighting.camera_position, i) - p[i];
      end
      n = unit_vec(nr);
      l = unit_vec(lr);
      v = unit_vec(vr);
      nl = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
      diff = clamp_one(nl);
      nl = trunc_shift(nl);
      for (int i = 0; i < 3; i++) refl[i] = -l[i] + trunc_shift(2 * nl * n[i]);
      spb = clamp_one(v[0] * refl[0] + v[1] * refl[1] + v[2] * refl[2]);
      spec = 64'd1 << FB;
      for (int e = 0; e < 8; e++) begin
         if (lighting.shininess[e]) spec = (spec * spb) >> FB;
         spb = (spb * spb) >> FB;
      end
      kd = lighting.material_factors[31:16];
      ks = lighting.material_factors[15:0];
      for (int i = 0; i < 3; i++) begin
         t = (ulane(lighting.light_color, i) * lighting.light_intensity) >> 8;
         d = (((t * kd) >> 8) * diff) >> FB;
         s = (((t * ks) >> 8) * spec) >> FB;
         a = (ulane(lighting.ambient_color, i) * lighting.ambient_intensity) >> 8;
         o = ((a + d + s) * base[i]) >> 8;
         res[i] = (o > 65535) ? 16'hFFFF : o[15:0];
      end
      c.r = res[0]; c.g = res[1]; c.b = res[2];
      return c;
   endfunction

   // ---------------- driver / monitor ----------------
   function automatic int pick_gap();
      int r;
      if (!allow_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_if.valid && req_if.ready) colors_due.push_back(shade(frag_on_bus));
         if (!req_if.valid || req_if.ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_if.valid <= 1'b0;
            end else if (frags_to_send.size() > 0) begin
               frag_on_bus = frags_to_send.pop_front();
               req_if.pos_x  <= frag_on_bus.px;
               req_if.pos_y  <= frag_on_bus.py;
               req_if.pos_z  <= frag_on_bus.pz;
               req_if.norm_x <= frag_on_bus.nx;
               req_if.norm_y <= frag_on_bus.ny;
               req_if.norm_z <= frag_on_bus.nz;
               req_if.base_r <= frag_on_bus.br;
               req_if.base_g <= frag_on_bus.bg;
               req_if.base_b <= frag_on_bus.bb;
               req_if.valid  <= 1'b1;
               req_gap <= pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      color_t want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (colors_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word r=%h g=%h b=%h",
                           rsp_if.out_r, rsp_if.out_g, rsp_if.out_b);
            end else begin
               want = colors_due.pop_front();
               if (rsp_if.out_r !== want.r || rsp_if.out_g !== want.g ||
                   rsp_if.out_b !== want.b) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("color mismatch: exp %h %h %h got %h %h %h",
                              want.r, want.g, want.b,
                              rsp_if.out_r, rsp_if.out_g, rsp_if.out_b);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            rsp_gap <= pick_gap();
         end
      end
   end

   // ---------------- stimulus ----------------
   task automatic write_reg(csr_index_type idx, logic [47:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         REG_LIGHT_POS:     lighting.light_position    = val;
         REG_CAMERA_POS:    lighting.camera_position   = val;
         REG_LIGHT_COLOR:   lighting.light_color       = val;
         REG_LIGHT_INT:     lighting.light_intensity   = val[15:0];
         REG_AMBIENT_COLOR: lighting.ambient_color     = val;
         REG_AMBIENT_INT:   lighting.ambient_intensity = val[15:0];
         REG_MATERIAL:      lighting.material_factors  = val[31:0];
         default:           lighting.shininess         = val[7:0];
      endcase
   endtask

   function automatic logic [47:0] rand48();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [15:0] rand16();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h8000;
      if (r == 1) return 16'h7FFF;
      if (r < 5) return $urandom_range(0, 2047) - 1024;
      return $urandom();
   endfunction

   function automatic frag_t rand_frag();
      frag_t f;
      f.px = rand16(); f.py = rand16(); f.pz = rand16();
      if ($urandom_range(0, 19) == 0) begin
         f.nx = 0; f.ny = 0; f.nz = 0;
      end else begin
         f.nx = rand16(); f.ny = rand16(); f.nz = rand16();
      end
      f.br = $urandom(); f.bg = $urandom(); f.bb = $urandom();
      return f;
   endfunction

   function automatic frag_t make_frag(int px, int py, int pz, int nx, int ny, int nz,
                                       int b);
      frag_t f;
      f.px = px; f.py = py; f.pz = pz;
      f.nx = nx; f.ny = ny; f.nz = nz;
      f.br = b; f.bg = 255 - b; f.bb = b;
      return f;
   endfunction

   task automatic drain();
      while (frags_to_send.size() > 0 || colors_due.size() > 0 || req_if.valid)
         @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   task automatic random_config();
      write_reg(REG_LIGHT_POS, rand48());
      write_reg(REG_CAMERA_POS, rand48());
      write_reg(REG_LIGHT_COLOR, rand48());
      write_reg(REG_LIGHT_INT, $urandom_range(0, 1023));
      write_reg(REG_AMBIENT_COLOR, rand48());
      write_reg(REG_AMBIENT_INT, $urandom_range(0, 511));
      write_reg(REG_MATERIAL, {$urandom_range(0, 767), 16'h0} | $urandom_range(0, 767));
      write_reg(REG_SHININESS, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 255));
   endtask

   initial begin
      lighting = CFG_RESET;
      mismatches = 0;
      allow_gaps = 1'b1;
      req_if.valid = 1'b0;
      req_if.pos_x = 0; req_if.pos_y = 0; req_if.pos_z = 0;
      req_if.norm_x = 0; req_if.norm_y = 0; req_if.norm_z = 0;
      req_if.base_r = 0; req_if.base_g = 0; req_if.base_b = 0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = REG_LIGHT_POS;
      csr_if.data  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // light above origin, camera in front, white light
      write_reg(REG_LIGHT_POS, {16'h0000, 16'h0A00, 16'h0000});
      write_reg(REG_CAMERA_POS, {16'h0000, 16'h0500, 16'h0A00});
      write_reg(REG_LIGHT_COLOR, {3{16'h0100}});
      write_reg(REG_AMBIENT_COLOR, {3{16'h0040}});
      write_reg(REG_AMBIENT_INT, 16'h0100);
      frags_to_send.push_back(make_frag(0, 0, 0, 0, 16384, 0, 255));
      frags_to_send.push_back(make_frag(0, 0, 0, 0, 0, 0, 255));          // zero normal
      frags_to_send.push_back(make_frag(0, 0, 0, 0, -16384, 0, 128));     // facing away
      frags_to_send.push_back(make_frag(0, 2560, 0, 0, 16384, 0, 255));   // at the light
      frags_to_send.push_back(make_frag(-32768, -32768, -32768, 32767, 32767, 32767, 255));
      frags_to_send.push_back(make_frag(32767, 32767, 32767, -32768, -32768, -32768, 0));
      frags_to_send.push_back(make_frag(0, 0, 0, -32768, 0, 0, 255));
      frags_to_send.push_back(make_frag(100, -100, 50, 1, 1, 1, 200));
      drain();

      // zero shininess, everything saturated
      write_reg(REG_SHININESS, 8'd0);
      write_reg(REG_LIGHT_COLOR, {3{16'hFFFF}});
      write_reg(REG_LIGHT_INT, 16'hFFFF);
      write_reg(REG_AMBIENT_COLOR, {3{16'hFFFF}});
      write_reg(REG_AMBIENT_INT, 16'hFFFF);
      write_reg(REG_MATERIAL, 32'hFFFF_FFFF);
      frags_to_send.push_back(make_frag(0, 0, 0, 0, 16384, 0, 255));
      frags_to_send.push_back(make_frag(0, 0, 0, 0, 0, 0, 1));
      frags_to_send.push_back(make_frag(0, 0, 0, 0, -16384, 0, 0));
      drain();

      // all-zero lighting, max exponent
      write_reg(REG_SHININESS, 8'd255);
      write_reg(REG_LIGHT_COLOR, '0);
      write_reg(REG_AMBIENT_INT, '0);
      write_reg(REG_MATERIAL, '0);
      write_reg(REG_LIGHT_POS, {16'h7FFF, 16'h8000, 16'h7FFF});
      write_reg(REG_CAMERA_POS, {16'h8000, 16'h7FFF, 16'h8000});
      frags_to_send.push_back(make_frag(0, 0, 0, 0, 16384, 0, 255));
      frags_to_send.push_back(make_frag(-32768, 32767, -32768, 16384, 0, 0, 255));
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         random_config();
         allow_gaps = (ph % 3 != 2);
         for (int k = 0; k < 125; k++) frags_to_send.push_back(rand_frag());
         drain();
      end

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/pll_pkg.sv
rtl/pll_ifs.sv
rtl/pll_front.sv
rtl/pll_queue.sv
rtl/pll_unit3.sv
rtl/pll_back.sv
rtl/phong_fragment_lighting_top.sv
rtl/pll_checker.sv
tb/phong_fragment_lighting_top_tb.sv
